@@ rtl/ptle_pkg.sv @@
// shared types and codes for the process table engine
`default_nettype none
package ptle_pkg;

  // command codes
  localparam logic [1:0] CMD_FORK = 2'd0;
  localparam logic [1:0] CMD_EXIT = 2'd1;
  localparam logic [1:0] CMD_WAIT = 2'd2;
  localparam logic [1:0] CMD_KILL = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_FAIL    = 2'd1;
  localparam logic [1:0] OUT_NONE    = 2'd2;
  localparam logic [1:0] OUT_BLOCKED = 2'd3;

  localparam int unsigned STATUS_BITS = 16;
  localparam logic [STATUS_BITS-1:0] KILL_STATUS = '1;

  typedef enum logic [1:0] {
    LS_RUNNING = 2'd0,
    LS_BLOCKED = 2'd1,
    LS_ZOMBIE  = 2'd2
  } life_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/ptle_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module ptle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/process_table_lifecycle_engine.sv @@
// top level of the process table engine: scan sequencer, decision and write-back
//
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_cmd, in_target_id, in_child_id,
//         |           | in_any_child, in_exit_code
// out     | output    | out_valid, out_stall, out_outcome, out_result_id, out_reaped_status
//
// each item is swept through the whole entry memory at one slot per cycle, read through
// the registered memory port, then decided and written back; decide waits while the
// output register holds a stalled result, and the engine is idle again before the next acceptance
// after reset the init state writes the first process into slot zero; in_stall is high
// until then
// in_stall is high whenever an item is in work; a stalled result holds in the output
// register and the next item may already be accepted and swept meanwhile
`default_nettype none
module process_table_lifecycle_engine
  import ptle_pkg::*;
#(
  parameter int SLOTS   = 64,
  parameter int INIT_ID = 1,
  parameter int ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_target_id,
  input  wire logic [15:0] in_child_id,
  input  wire logic        in_any_child,
  input  wire logic signed [15:0] in_exit_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_outcome,
  output logic [15:0]      out_result_id,
  output logic signed [15:0] out_reaped_status
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // compare width: wide enough for both stored ids and 16-bit ports
  localparam int CW = (ID_BITS > 16) ? ID_BITS : 16;
  // entry layout: {proc_id, parent_id, life_state, exit_value}
  localparam int EW      = 2 * ID_BITS + 2 + STATUS_BITS;
  localparam int EX_LO   = 0;
  localparam int ST_LO   = STATUS_BITS;
  localparam int PAR_LO  = STATUS_BITS + 2;
  localparam int PID_LO  = STATUS_BITS + 2 + ID_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_t state_r, state_nxt;

  // captured command
  logic [1:0]             cmd_r;
  logic [CW-1:0]          tgt_r;
  logic [CW-1:0]          child_r;
  logic                   any_r;
  logic [STATUS_BITS-1:0] code_r;

  // sweep pipeline
  logic          issue_r, issue_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic          rd_last_r;

  logic [SLOTS-1:0] used_r, used_nxt;
  logic [ID_BITS:0] next_id_r, next_id_nxt;

  // sweep accumulators
  logic                   tgt_hit_r;
  logic [IW-1:0]          tgt_idx_r;
  logic [EW-1:0]          tgt_ent_r;
  logic                   free_hit_r;
  logic [IW-1:0]          free_idx_r;
  logic                   kid_seen_r;
  logic                   named_hit_r;
  logic                   named_zmb_r;
  logic [ID_BITS-1:0]     named_id_r;
  logic [STATUS_BITS-1:0] named_ex_r;
  logic [IW-1:0]          named_idx_r;
  logic                   pick_hit_r;
  logic [ID_BITS-1:0]     pick_id_r;
  logic [STATUS_BITS-1:0] pick_ex_r;
  logic [IW-1:0]          pick_idx_r;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             outcome_r, outcome_nxt;
  logic [15:0]            rid_r, rid_nxt;
  logic [STATUS_BITS-1:0] rst_r, rst_nxt;

  // memory port
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  logic in_acc, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  ptle_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue_r),
    .raddr (scan_r),
    .rdata (rdata)
  );

  // fields of the entry coming out of the memory
  logic [ID_BITS-1:0]     e_pid, e_par;
  logic [1:0]             e_st;
  logic [STATUS_BITS-1:0] e_ex;
  logic                   e_used, e_is_tgt, e_is_kid;

  assign e_pid    = rdata[PID_LO +: ID_BITS];
  assign e_par    = rdata[PAR_LO +: ID_BITS];
  assign e_st     = rdata[ST_LO +: 2];
  assign e_ex     = rdata[EX_LO +: STATUS_BITS];
  assign e_used   = used_r[rd_idx_r];
  // id zero never names a process
  assign e_is_tgt = e_used && (tgt_r != '0) && (CW'(e_pid) == tgt_r);
  assign e_is_kid = e_used && (CW'(e_par) == tgt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:   state_nxt = S_IDLE;
      S_IDLE:   if (in_acc) state_nxt = S_SCAN;
      S_SCAN:   if (rd_vld_r && rd_last_r) state_nxt = S_DECIDE;
      S_DECIDE: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sweep address sequencing
  always_comb begin
    issue_nxt = issue_r;
    scan_nxt  = scan_r;
    if (state_r == S_IDLE && in_acc) begin
      issue_nxt = 1'b1;
      scan_nxt  = '0;
    end else if (issue_r) begin
      if (scan_r == LAST_IDX) begin
        issue_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + 1'b1;
      end
    end
  end

  // decision and write-back
  logic [CW-1:0] new_id_ext;
  assign new_id_ext = CW'(next_id_r[ID_BITS-1:0]);

  always_comb begin
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    used_nxt      = used_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    outcome_nxt   = outcome_r;
    rid_nxt       = rid_r;
    rst_nxt       = rst_r;

    if (state_r == S_INIT) begin
      // first process lives in slot zero
      we    = 1'b1;
      waddr = '0;
      wdata = {ID_BITS'(INIT_ID), {ID_BITS{1'b0}}, LS_RUNNING, {STATUS_BITS{1'b0}}};
    end else if (state_r == S_DECIDE && out_free) begin
      out_valid_nxt = 1'b1;
      outcome_nxt   = OUT_FAIL;
      rid_nxt       = '0;
      rst_nxt       = '0;
      if (tgt_hit_r) begin
        case (cmd_r)
          CMD_FORK: begin
            if (tgt_ent_r[ST_LO +: 2] == LS_RUNNING) begin
              // a running parent burns an id whenever one is left
              if (!next_id_r[ID_BITS]) begin
                next_id_nxt = next_id_r + 1'b1;
                if (free_hit_r) begin
                  we                   = 1'b1;
                  waddr                = free_idx_r;
                  wdata                = {next_id_r[ID_BITS-1:0], tgt_r[ID_BITS-1:0],
                                          LS_RUNNING, {STATUS_BITS{1'b0}}};
                  used_nxt[free_idx_r] = 1'b1;
                  outcome_nxt          = OUT_OK;
                  rid_nxt              = new_id_ext[15:0];
                end
              end
            end
          end
          CMD_EXIT, CMD_KILL: begin
            we          = 1'b1;
            waddr       = tgt_idx_r;
            wdata       = tgt_ent_r;
            wdata[ST_LO +: 2] = LS_ZOMBIE;
            wdata[EX_LO +: STATUS_BITS] = (cmd_r == CMD_EXIT) ? code_r : KILL_STATUS;
            outcome_nxt = OUT_OK;
          end
          default: begin
            // wait
            if (!any_r && !named_hit_r) begin
              outcome_nxt = OUT_FAIL;
            end else if (!kid_seen_r) begin
              outcome_nxt = OUT_NONE;
            end else if (any_r ? pick_hit_r : named_zmb_r) begin
              used_nxt[any_r ? pick_idx_r : named_idx_r] = 1'b0;
              we          = 1'b1;
              waddr       = tgt_idx_r;
              wdata       = tgt_ent_r;
              wdata[ST_LO +: 2] = LS_RUNNING;
              outcome_nxt = OUT_OK;
              rid_nxt     = 16'(any_r ? pick_id_r : named_id_r);
              rst_nxt     = any_r ? pick_ex_r : named_ex_r;
            end else begin
              we          = 1'b1;
              waddr       = tgt_idx_r;
              wdata       = tgt_ent_r;
              wdata[ST_LO +: 2] = LS_BLOCKED;
              outcome_nxt = OUT_BLOCKED;
            end
          end
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      used_r      <= SLOTS'(1);
      next_id_r   <= (ID_BITS+1)'(INIT_ID + 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= issue_r;
      used_r      <= used_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers and sweep accumulators
  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    rd_idx_r  <= scan_r;
    rd_last_r <= (scan_r == LAST_IDX);
    outcome_r <= outcome_nxt;
    rid_r     <= rid_nxt;
    rst_r     <= rst_nxt;
    if (state_r == S_IDLE && in_acc) begin
      cmd_r       <= in_cmd;
      tgt_r       <= CW'(in_target_id);
      child_r     <= CW'(in_child_id);
      any_r       <= in_any_child;
      code_r      <= in_exit_code;
      tgt_hit_r   <= 1'b0;
      free_hit_r  <= 1'b0;
      kid_seen_r  <= 1'b0;
      named_hit_r <= 1'b0;
      pick_hit_r  <= 1'b0;
    end else if (rd_vld_r) begin
      if (e_is_tgt) begin
        tgt_hit_r <= 1'b1;
        tgt_idx_r <= rd_idx_r;
        tgt_ent_r <= rdata;
      end
      // lowest free slot
      if (!e_used && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (e_is_kid) begin
        kid_seen_r <= 1'b1;
        if (child_r != '0 && CW'(e_pid) == child_r) begin
          named_hit_r <= 1'b1;
          named_zmb_r <= (e_st == LS_ZOMBIE);
          named_id_r  <= e_pid;
          named_ex_r  <= e_ex;
          named_idx_r <= rd_idx_r;
        end
        // oldest zombie child has the lowest id
        if (e_st == LS_ZOMBIE && (!pick_hit_r || e_pid < pick_id_r)) begin
          pick_hit_r <= 1'b1;
          pick_id_r  <= e_pid;
          pick_ex_r  <= e_ex;
          pick_idx_r <= rd_idx_r;
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_outcome       = outcome_r;
  assign out_result_id     = rid_r;
  assign out_reaped_status = rst_r;

  // a new result only comes from the decide step
  a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_DECIDE))
    else $error("result appeared outside decide");

  // a fork never lands on an occupied slot
  a_fork_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && we && cmd_r == CMD_FORK) |-> !used_r[free_idx_r])
    else $error("fork overwrote a used slot");

  // no memory read is issued outside the sweep
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r |-> (state_r == S_SCAN))
    else $error("memory read outside sweep");

  // the sweep ends in the decide step
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rd_vld_r && rd_last_r) |=> (state_r == S_DECIDE))
    else $error("sweep did not end in decide");

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the process table lifecycle engine
`timescale 1ns / 1ps
module testbench;
  import ptle_pkg::*;

  localparam int SLOTS     = 64;
  localparam int INIT_ID   = 1;
  localparam int ID_BITS   = 16;
  localparam int ID_LIMIT  = (1 << ID_BITS) - 1;
  localparam int MAX_CYCLES = 1500000;
  localparam int HOLD_CYCLES = 1500;
  localparam logic [15:0] INIT_PID = 16'(INIT_ID);

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] result_id;
    logic [15:0] reaped_status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_FORK;
  logic [15:0] in_target_id = '0;
  logic [15:0] in_child_id = '0;
  logic        in_any_child = 1'b0;
  logic signed [15:0] in_exit_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_outcome;
  logic [15:0] out_result_id;
  logic signed [15:0] out_reaped_status;

  process_table_lifecycle_engine #(
    .SLOTS(SLOTS), .INIT_ID(INIT_ID), .ID_BITS(ID_BITS)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_target_id(in_target_id), .in_child_id(in_child_id),
    .in_any_child(in_any_child), .in_exit_code(in_exit_code),
    .out_valid(out_valid), .out_stall(out_stall), .out_outcome(out_outcome),
    .out_result_id(out_result_id), .out_reaped_status(out_reaped_status)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow process table, updated whenever the block accepts an item
  bit          tbl_used [SLOTS];
  logic [15:0] tbl_pid [SLOTS];
  logic [15:0] tbl_ppid [SLOTS];
  life_t       tbl_life [SLOTS];
  logic [15:0] tbl_status [SLOTS];
  logic [16:0] tbl_next_id;

  answer_t answers_due [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      sender_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 0;
      tbl_pid[i] = '0;
      tbl_ppid[i] = '0;
      tbl_life[i] = LS_RUNNING;
      tbl_status[i] = '0;
    end
    tbl_used[0] = 1;
    tbl_pid[0] = INIT_PID;
    tbl_next_id = 17'(INIT_ID + 1);
  endfunction

  // slot holding id, -1 when none; id zero never matches
  function automatic int find_slot(logic [15:0] id);
    if (id == 0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_used[i] && tbl_pid[i] == id) return i;
    return -1;
  endfunction

  // applies one command to the shadow table and returns the answer it yields
  function automatic answer_t apply_command(logic [1:0] cmd, logic [15:0] target,
                                            logic [15:0] child, logic any,
                                            logic [15:0] code);
    answer_t a;
    int t;
    int free_slot;
    int count;
    int named;
    int pick;
    logic [16:0] id;
    a = '{OUT_FAIL, 16'd0, 16'd0};
    t = find_slot(target);
    free_slot = -1;
    count = 0;
    named = -1;
    pick = -1;
    if (t < 0) return a;
    case (cmd)
      CMD_FORK: begin
        if (tbl_life[t] != LS_RUNNING) return a;
        // a running parent burns the id even if the fork fails below
        id = tbl_next_id;
        if (tbl_next_id <= ID_LIMIT) tbl_next_id++;
        if (id > ID_LIMIT) return a;
        for (int i = 0; i < SLOTS; i++)
          if (!tbl_used[i]) begin
            free_slot = i;
            break;
          end
        if (free_slot < 0) return a;
        tbl_used[free_slot] = 1;
        tbl_pid[free_slot] = id[15:0];
        tbl_ppid[free_slot] = target;
        tbl_life[free_slot] = LS_RUNNING;
        tbl_status[free_slot] = '0;
        a = '{OUT_OK, id[15:0], 16'd0};
      end
      CMD_EXIT, CMD_KILL: begin
        tbl_life[t] = LS_ZOMBIE;
        tbl_status[t] = (cmd == CMD_EXIT) ? code : KILL_STATUS;
        a = '{OUT_OK, 16'd0, 16'd0};
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_used[i] || tbl_ppid[i] != target) continue;
          count++;
          if (child != 0 && tbl_pid[i] == child) named = i;
          if (any && tbl_life[i] == LS_ZOMBIE && (pick < 0 || tbl_pid[i] < tbl_pid[pick]))
            pick = i;
        end
        if (!any && named < 0) return a;
        if (count == 0) return '{OUT_NONE, 16'd0, 16'd0};
        if (!any) pick = (tbl_life[named] == LS_ZOMBIE) ? named : -1;
        if (pick >= 0) begin
          a = '{OUT_OK, tbl_pid[pick], tbl_status[pick]};
          tbl_used[pick] = 0;
          tbl_pid[pick] = '0;
          tbl_ppid[pick] = '0;
          tbl_life[pick] = LS_RUNNING;
          tbl_status[pick] = '0;
          tbl_life[t] = LS_RUNNING;
        end else begin
          tbl_life[t] = LS_BLOCKED;
          a = '{OUT_BLOCKED, 16'd0, 16'd0};
        end
      end
    endcase
    return a;
  endfunction

  // offers one item, waits for acceptance, then maybe idles
  task automatic send_item(logic [1:0] cmd, logic [15:0] target, logic [15:0] child,
                           logic any, logic [15:0] code);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_target_id <= target;
    in_child_id <= child;
    in_any_child <= any;
    in_exit_code <= code;
    do @(posedge clk); while (in_stall);
    answers_due.push_back(apply_command(cmd, target, child, any, code));
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // receiver stall, with a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $error("result with nothing expected: outcome %0d", out_outcome);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (out_outcome !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, out_outcome);
          mismatches++;
        end
        if (out_result_id !== want.result_id) begin
          $error("result_id: expected %0d, actual %0d", want.result_id, out_result_id);
          mismatches++;
        end
        if (out_reaped_status !== want.reaped_status) begin
          $error("reaped_status: expected %0d, actual %0d",
                 $signed(want.reaped_status), out_reaped_status);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // directed walk through each outcome and corner of the lifecycle
  task automatic test_directed();
    send_item(CMD_WAIT, INIT_PID, 16'd0, 1'b1, 16'd0);     // no children
    send_item(CMD_WAIT, INIT_PID, 16'd5, 1'b0, 16'd0);     // stranger, no children
    send_item(CMD_FORK, INIT_PID, 16'd0, 1'b0, 16'd0);     // id 2
    send_item(CMD_FORK, 16'd0, 16'hFFFF, 1'b1, 16'hFFFF);  // id zero never matches
    send_item(CMD_FORK, 16'hFFFF, 16'd0, 1'b0, 16'd0);     // lookup miss
    send_item(CMD_EXIT, 16'd999, 16'd0, 1'b0, 16'd7);      // lookup miss on exit
    send_item(CMD_WAIT, INIT_PID, 16'd2, 1'b0, 16'd0);     // blocks init
    send_item(CMD_FORK, INIT_PID, 16'd0, 1'b0, 16'd0);     // blocked parent, no id burnt
    send_item(CMD_EXIT, 16'd2, 16'd0, 1'b0, 16'h8000);
    send_item(CMD_EXIT, 16'd2, 16'd0, 1'b0, 16'h7FFF);     // status overwrite
    send_item(CMD_WAIT, INIT_PID, 16'hFFFF, 1'b1, 16'd0);  // reap 2, init running
    send_item(CMD_FORK, INIT_PID, 16'd0, 1'b0, 16'd0);     // id 3
    send_item(CMD_FORK, 16'd3, 16'd0, 1'b0, 16'd0);        // id 4
    send_item(CMD_KILL, 16'd4, 16'd0, 1'b0, 16'h1234);
    send_item(CMD_KILL, 16'd3, 16'd0, 1'b0, 16'd0);
    send_item(CMD_FORK, 16'd3, 16'd0, 1'b0, 16'd0);        // zombie parent
    send_item(CMD_WAIT, 16'd3, 16'd0, 1'b1, 16'd0);        // reap 4 with kill status
    send_item(CMD_WAIT, 16'd3, 16'd4, 1'b0, 16'd0);        // reaped child now a stranger
    send_item(CMD_WAIT, 16'd3, 16'd0, 1'b1, 16'd0);        // no children
    send_item(CMD_KILL, INIT_PID, 16'd0, 1'b0, 16'd0);     // init a zombie
    send_item(CMD_WAIT, INIT_PID, 16'd3, 1'b0, 16'd0);     // reap 3, init running again
    send_item(CMD_EXIT, 16'd0, 16'd0, 1'b0, 16'd0);
    send_item(CMD_WAIT, INIT_PID, 16'd0, 1'b1, 16'd0);
  endtask

  // fork until the table is full, then kill and reap everything again
  task automatic test_table_full();
    int used;
    used = 0;
    for (int i = 0; i < SLOTS; i++) used += tbl_used[i];
    for (int i = 0; i < SLOTS - used + 2; i++)
      send_item(CMD_FORK, INIT_PID, 16'd0, 1'b0, 16'($urandom));
    for (int i = 1; i < SLOTS; i++)
      if (tbl_used[i] && tbl_ppid[i] == INIT_PID) begin
        send_item($urandom_range(1) ? CMD_KILL : CMD_EXIT, tbl_pid[i], 16'd0, 1'b0,
                  16'($urandom));
        send_item(CMD_WAIT, INIT_PID, $urandom_range(1) ? tbl_pid[i] : 16'd0,
                  1'b1, 16'd0);
      end
  endtask

  // random command mix drawn mostly from live processes
  task automatic test_random(int count);
    logic [1:0]  cmd;
    logic [15:0] target;
    logic [15:0] child;
    logic        any;
    int          k;
    int          r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      do k = $urandom_range(SLOTS - 1); while (!tbl_used[k]);
      target = tbl_pid[k];
      child = 16'($urandom);
      any = 1'($urandom_range(1));
      if (r < 35) begin
        cmd = CMD_FORK;
        if ($urandom_range(1)) target = INIT_PID;
      end else if (r < 58) begin
        cmd = $urandom_range(1) ? CMD_EXIT : CMD_KILL;
        if (k == 0) cmd = CMD_FORK;  // keep init alive
      end else begin
        cmd = CMD_WAIT;
        do k = $urandom_range(SLOTS - 1); while (!tbl_used[k]);
        if (k != 0 && $urandom_range(9) < 8) begin
          target = tbl_ppid[k];
          child = tbl_pid[k];
        end
      end
      // noise: arbitrary or zero target ids
      if ($urandom_range(99) < 6) target = $urandom_range(1) ? 16'($urandom) : 16'd0;
      send_item(cmd, target, child, any, 16'($urandom));
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random(20);
  endtask

  initial begin
    clear_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random(80);
    sender_idle_pct = 84;
    test_random(80);
    sender_idle_pct = 0;
    recv_stall_pct = 84;
    test_random(80);
    sender_idle_pct = 28;
    recv_stall_pct = 28;
    test_random(80);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SLOTS * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
